// ----- rtl/core/mos_pkg.sv -----
// Shared types and constants for the median of two sorted lists block.
// Used by the front, back and top-level modules; depends on nothing else.
package mos_pkg;

	localparam int VALUE_W  = 32;
	localparam int MEDIAN_W = 33;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;

	// Item mode codes on the input channel.
	localparam logic [MODE_W-1:0] MODE_APPEND_A = 2'd0;
	localparam logic [MODE_W-1:0] MODE_APPEND_B = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FINISH   = 2'd2;

	// Status codes on the result channel.
	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

	// Command queue between the front and the back.
	localparam int                QUEUE_DEPTH = 4;
	localparam int                QUEUE_AW    = 2;
	localparam logic [QUEUE_AW:0] QUEUE_FULL  = 3'd4;

	typedef enum logic [1:0] {
		CMD_APPEND_A,
		CMD_APPEND_B,
		CMD_FINISH
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                  kind;
		logic signed [VALUE_W-1:0]  value;
	} cmd_t;

endpackage

// ----- rtl/core/mos_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module mos_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ----- rtl/core/mos_front.sv -----
// Front end: accepts input items, decodes the mode and queues commands.
// Depends on mos_pkg for the command type and the mode codes.
module mos_front
	import mos_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [MODE_W-1:0]          mode,
	input  logic signed [VALUE_W-1:0]  value,
	output logic                       q_valid,
	output cmd_t                       q_cmd,
	input  logic                       q_pop
);

	cmd_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW:0]   fill_q;
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic                accept;
	logic                push;
	logic                pop;
	cmd_t                new_cmd;

	assign in_stall = (fill_q == QUEUE_FULL);
	assign accept   = in_valid && !in_stall;
	assign q_valid  = (fill_q != '0);
	assign q_cmd    = entry_q[rd_ptr_q];
	assign pop      = q_pop && q_valid;

	// Classify the item; an unused mode code is dropped here.
	always_comb begin
		new_cmd.value = value;
		new_cmd.kind  = CMD_FINISH;
		push          = accept;
		case (mode)
			MODE_APPEND_A: new_cmd.kind = CMD_APPEND_A;
			MODE_APPEND_B: new_cmd.kind = CMD_APPEND_B;
			MODE_FINISH:   new_cmd.kind = CMD_FINISH;
			default:       push = 1'b0;
		endcase
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_cmd;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/mos_back.sv -----
// Back end: stores list elements, runs the merge walk and holds the result.
// Depends on mos_pkg and instantiates mos_ram for each list.
module mos_back
	import mos_pkg::*;
#(
	parameter int LIST_DEPTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  cmd_t                        q_cmd,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [MEDIAN_W-1:0]  median_doubled,
	output logic [STATUS_W-1:0]         status
);

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int TW = CW + 1;
	localparam logic [CW-1:0] COUNT_FULL = CW'(LIST_DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                 state_q;
	logic [CW-1:0]              cnt_a_q;
	logic [CW-1:0]              cnt_b_q;
	logic                       ovf_q;
	logic [CW-1:0]              idx_a_q;
	logic [CW-1:0]              idx_b_q;
	logic [CW-1:0]              step_q;
	logic signed [VALUE_W-1:0]  prev_q;
	logic signed [VALUE_W-1:0]  cur_q;
	logic [STATUS_W-1:0]        status_q;
	logic                       out_valid_q;

	logic [TW-1:0]              total;
	logic [CW-1:0]              half;
	logic                       odd;
	logic                       head_a_ok;
	logic                       head_b_ok;
	logic                       take_a;
	logic                       take_b;
	logic signed [VALUE_W-1:0]  rd_a;
	logic signed [VALUE_W-1:0]  rd_b;
	logic signed [VALUE_W-1:0]  pick;
	logic [CW-1:0]              idx_a_nxt;
	logic [CW-1:0]              idx_b_nxt;
	logic                       pop;
	logic                       wr_a;
	logic                       wr_b;
	logic                       out_free;
	logic signed [MEDIAN_W-1:0] sum;

	assign q_pop     = (state_q == ST_IDLE);
	assign pop       = q_pop && q_valid;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Combined length and the middle position of the walk.
	assign total = {1'b0, cnt_a_q} + {1'b0, cnt_b_q};
	assign half  = total[TW-1:1];
	assign odd   = total[0];

	// Merge step: take the first head when it is strictly smaller.
	assign head_a_ok = (idx_a_q < cnt_a_q);
	assign head_b_ok = (idx_b_q < cnt_b_q);
	assign take_a    = head_a_ok && (!head_b_ok || (rd_a < rd_b));
	assign take_b    = !take_a && head_b_ok;
	assign pick      = take_a ? rd_a : (take_b ? rd_b : '0);

	// Next read positions; the RAMs are addressed ahead so data lines up.
	always_comb begin
		idx_a_nxt = idx_a_q;
		idx_b_nxt = idx_b_q;
		case (state_q)
			ST_IDLE: begin
				idx_a_nxt = '0;
				idx_b_nxt = '0;
			end
			ST_WALK: begin
				idx_a_nxt = idx_a_q + CW'(take_a);
				idx_b_nxt = idx_b_q + CW'(take_b);
			end
			default: ;
		endcase
	end

	// Appends that fit are written at the current count.
	assign wr_a = pop && (q_cmd.kind == CMD_APPEND_A) && (cnt_a_q != COUNT_FULL);
	assign wr_b = pop && (q_cmd.kind == CMD_APPEND_B) && (cnt_b_q != COUNT_FULL);

	mos_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (LIST_DEPTH)
	) u_list_a (
		.clk     (clk),
		.wr_en   (wr_a),
		.wr_addr (cnt_a_q[AW-1:0]),
		.wr_data (q_cmd.value),
		.rd_addr (idx_a_nxt[AW-1:0]),
		.rd_data (rd_a)
	);

	mos_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (LIST_DEPTH)
	) u_list_b (
		.clk     (clk),
		.wr_en   (wr_b),
		.wr_addr (cnt_b_q[AW-1:0]),
		.wr_data (q_cmd.value),
		.rd_addr (idx_b_nxt[AW-1:0]),
		.rd_data (rd_b)
	);

	// Twice the median from the last element (odd) or last two (even) of the walk.
	always_comb begin
		if (odd) begin
			sum = {cur_q, 1'b0};
		end else begin
			sum = {prev_q[VALUE_W-1], prev_q} + {cur_q[VALUE_W-1], cur_q};
		end
	end

	// Walk and output registers carry data only.
	always_ff @(posedge clk) begin
		if (state_q == ST_WALK) begin
			prev_q <= cur_q;
			cur_q  <= pick;
		end
		if (state_q == ST_DONE && out_free) begin
			median_doubled <= (status_q == STATUS_OK) ? sum : '0;
			status         <= status_q;
		end
	end

	// Command sequencing, list counts and the output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			ovf_q       <= 1'b0;
			idx_a_q     <= '0;
			idx_b_q     <= '0;
			step_q      <= '0;
			status_q    <= STATUS_OK;
			out_valid_q <= 1'b0;
		end else begin
			idx_a_q <= idx_a_nxt;
			idx_b_q <= idx_b_nxt;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (q_cmd.kind)
							CMD_APPEND_A: begin
								if (cnt_a_q != COUNT_FULL) begin
									cnt_a_q <= cnt_a_q + 1'b1;
								end else begin
									ovf_q <= 1'b1;
								end
							end
							CMD_APPEND_B: begin
								if (cnt_b_q != COUNT_FULL) begin
									cnt_b_q <= cnt_b_q + 1'b1;
								end else begin
									ovf_q <= 1'b1;
								end
							end
							CMD_FINISH: begin
								step_q <= '0;
								if (ovf_q) begin
									status_q <= STATUS_OVERFLOW;
									state_q  <= ST_DONE;
								end else if (total == '0) begin
									status_q <= STATUS_EMPTY;
									state_q  <= ST_DONE;
								end else begin
									status_q <= STATUS_OK;
									state_q  <= ST_WALK;
								end
							end
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					step_q <= step_q + 1'b1;
					if (step_q == half) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						cnt_a_q     <= '0;
						cnt_b_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/median_of_two_sorted_lists.sv -----
// Median of two sorted lists: the input channel carries mode and value
// items; mode 0 appends value to the first list, mode 1 to the second,
// mode 2 finishes and yields one result item, mode 3 is discarded.
// Each list holds LIST_DEPTH elements in its own RAM. A result item gives
// twice the median (one fractional bit) and a status: ok, both lists
// empty, or a list overflowed (appends to a full list are dropped).
// Every finish clears both lists.
// Items pass through a four-entry command queue; in_stall rises only when
// it is full. Appends leave the queue only while the back end is idle.
// After a finish leaves the queue, the merge walk reads one element per
// cycle from the two list RAMs up to position half, where half is the
// combined length divided by two; the RAM reads are addressed ahead,
// and the output register is loaded last. Error results skip the walk.
// The result waits in an output register while out_stall is high; the
// queue keeps taking items meanwhile, and the back end holds further work
// only when a second result would overwrite the first.
// Reset empties the queue and both lists and clears the overflow flag.
// Depends on mos_pkg, mos_front, mos_back and mos_ram.
module median_of_two_sorted_lists
	import mos_pkg::*;
#(
	parameter int LIST_DEPTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [MODE_W-1:0]           mode,
	input  logic signed [VALUE_W-1:0]   value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [MEDIAN_W-1:0]  median_doubled,
	output logic [STATUS_W-1:0]         status
);

	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	// Front end with the command queue.
	mos_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.value    (value),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop)
	);

	// Back end with the list stores and the merge walk.
	mos_back #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_cmd          (q_cmd),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.median_doubled (median_doubled),
		.status         (status)
	);

endmodule
